/* design/mexp_pkg.sv */
// Shared types and constants for the modular exponentiation core.
package mexp_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd1;

    // Exponentiation sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_MUL,
        S_SQR,
        S_DONE
    } t_state;

    // Status of the shared modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

/* design/modular_exponentiation_core.sv */
// Modular exponentiation core: power_mod = base ^ exponent mod modulus.
//
// Configuration: write exponent (index 0) and modulus (index 1) through the
// write port while the core is idle; both are sampled when a base transfers.
// Input channel: i_in_valid / o_in_stall carry i_base. o_in_stall is high
// from the transfer of a base until its result has moved into the output
// register, so one base is in work at a time.
// Output channel: o_out_valid / i_out_stall carry o_power_mod. The output
// register holds the result while the receiver stalls; a new base may be
// taken meanwhile, and its finished result waits until the register frees.
// Sequence: each modular multiply runs bit-serially in the shared multiplier,
// one bit per cycle (W = OPERAND_WIDTH). An item uses one reduction of the
// base, W squarings and one multiply per set exponent bit, and the next base
// can transfer once the result has moved into the output register. A zero
// modulus skips the multiplies and returns 0.
// Reset: synchronous, active low; exponent resets to 0, modulus to 1, no
// result pending.
module modular_exponentiation_core #(
    parameter int unsigned OPERAND_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mexp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [OPERAND_WIDTH-1:0]        i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [OPERAND_WIDTH-1:0]        i_base,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [OPERAND_WIDTH-1:0]        o_power_mod
);
    import mexp_pkg::*;

    localparam int unsigned W     = OPERAND_WIDTH;
    localparam int unsigned CNT_W = $clog2(W);

    // Configuration registers
    logic [W-1:0] r_exponent;
    logic [W-1:0] r_modulus;

    // Sequencer control
    t_state           r_state, n_state;
    logic             r_wait, n_wait;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    // Working values
    logic [W-1:0] r_n, n_n;
    logic [W-1:0] r_e, n_e;
    logic [W-1:0] r_base, n_base;
    logic [W-1:0] r_acc, n_acc;
    logic [W-1:0] r_sq, n_sq;
    logic [W-1:0] r_power_mod, n_power_mod;

    // Multiplier interface
    logic         mul_start;
    logic [W-1:0] mul_a;
    logic [W-1:0] mul_b;
    logic [W-1:0] mul_res;
    t_mul_stat    mul_stat;
    logic [W-1:0] one_mod;
    logic         in_xfer;

    assign one_mod   = (r_n == W'(1)) ? '0 : W'(1);
    assign in_xfer   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    mexp_modmul #(
        .OPERAND_WIDTH(W)
    ) u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_n     (r_n),
        .o_stat  (mul_stat),
        .o_result(mul_res)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= '0;
            r_modulus  <= W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_EXPONENT: r_exponent <= i_cfg_data;
                CFG_MODULUS:  r_modulus  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wait      <= n_wait;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_e         <= n_e;
        r_base      <= n_base;
        r_acc       <= n_acc;
        r_sq        <= n_sq;
        r_power_mod <= n_power_mod;
    end

    // Sequencer: reduce base, then square-and-multiply from the exponent LSB
    always_comb begin
        n_state     = r_state;
        n_wait      = r_wait;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_e         = r_e;
        n_base      = r_base;
        n_acc       = r_acc;
        n_sq        = r_sq;
        n_power_mod = r_power_mod;
        n_out_valid = r_out_valid;
        mul_start   = 1'b0;
        mul_a       = r_sq;
        mul_b       = r_sq;

        // Drop the output once it transfers
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // Issue one multiply per compute state, then wait for it
        if (!r_wait && (r_state == S_RED || r_state == S_MUL || r_state == S_SQR)) begin
            mul_start = 1'b1;
            n_wait    = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_n    = r_modulus;
                    n_e    = r_exponent;
                    n_base = i_base;
                    n_cnt  = '0;
                    n_wait = 1'b0;
                    if (r_modulus == '0) begin
                        n_acc   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RED;
                    end
                end
            end
            S_RED: begin
                mul_a = one_mod;
                mul_b = r_base;
                if (r_wait && mul_stat.done) begin
                    n_sq    = mul_res;
                    n_acc   = one_mod;
                    n_wait  = 1'b0;
                    n_state = r_e[0] ? S_MUL : S_SQR;
                end
            end
            S_MUL: begin
                mul_a = r_acc;
                mul_b = r_sq;
                if (r_wait && mul_stat.done) begin
                    n_acc   = mul_res;
                    n_wait  = 1'b0;
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                if (r_wait && mul_stat.done) begin
                    n_sq   = mul_res;
                    n_e    = {1'b0, r_e[W-1:1]};
                    n_cnt  = r_cnt + 1'b1;
                    n_wait = 1'b0;
                    if (r_cnt == CNT_W'(W - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = r_e[1] ? S_MUL : S_SQR;
                    end
                end
            end
            S_DONE: begin
                // Hold the result until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_power_mod = r_acc;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_power_mod = r_power_mod;

`ifndef SYNTHESIS
    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> ((r_n == '0) ? (r_acc == '0) : (r_acc < r_n)))
        else $error("result not reduced by modulus");
    a_start_idle_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> !mul_stat.busy)
        else $error("multiply issued while multiplier busy");
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_stat.done |-> r_wait)
        else $error("multiplier finished with no multiply pending");
    a_operands_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_SQR) |-> (r_sq < r_n && r_acc < r_n))
        else $error("working values not reduced");
`endif

endmodule

/* design/mexp_modmul.sv */
// Bit-serial interleaved modular multiplier: one bit of b per cycle, MSB first.
module mexp_modmul #(
    parameter int unsigned OPERAND_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [OPERAND_WIDTH-1:0]       i_a,
    input  logic [OPERAND_WIDTH-1:0]       i_b,
    input  logic [OPERAND_WIDTH-1:0]       i_n,
    output mexp_pkg::t_mul_stat            o_stat,
    output logic [OPERAND_WIDTH-1:0]       o_result
);
    import mexp_pkg::*;

    localparam int unsigned W     = OPERAND_WIDTH;
    localparam int unsigned CNT_W = $clog2(W);

    // (x + y) mod n for x, y < n
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] x,
                                             input logic [W-1:0] y,
                                             input logic [W-1:0] n);
        logic [W:0] s;
        logic [W:0] d;
        s = {1'b0, x} + {1'b0, y};
        d = s - {1'b0, n};
        if (s >= {1'b0, n}) begin
            return d[W-1:0];
        end
        return s[W-1:0];
    endfunction

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_acc;
    logic [W-1:0]     r_a;
    logic [W-1:0]     r_b;
    logic [W-1:0]     r_n;
    logic [W-1:0]     n_dbl;
    logic [W-1:0]     n_acc;

    // Double the accumulator, then add a when the current bit of b is set
    always_comb begin
        n_dbl = add_mod(r_acc, r_acc, r_n);
        n_acc = r_b[W-1] ? add_mod(n_dbl, r_a, r_n) : n_dbl;
    end

    // Control: busy while stepping through the bits of b, done for one cycle after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: latch operands on start, advance one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_n   <= i_n;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[W-2:0], 1'b0};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_acc;

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("multiplier done while still busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !r_busy) |=> r_busy)
        else $error("multiplier did not start");
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt != '0) |-> (r_acc < r_n))
        else $error("multiplier accumulator not reduced");
`endif

endmodule

/* tb/tb_modular_exponentiation_core.sv */
// Self-checking testbench for the modular exponentiation core.
module tb_modular_exponentiation_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mexp_pkg::*;

    localparam int unsigned W = 32;
    // Cycles without any transfer before the run is declared hung
    localparam int unsigned QUIET_LIMIT = 20000;
    // Long receiver hold-off so the core fills up and stalls its input
    localparam int unsigned HOLD_CYCLES = 6000;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned RANDOM_PHASES = 12;
    localparam int unsigned ITEMS_PER_PHASE = 22;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_EXPONENT;
    logic [W-1:0]         i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [W-1:0]         i_base = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [W-1:0]         o_power_mod;

    // Key copy tracked from the write port
    logic [W-1:0] key_exponent;
    logic [W-1:0] key_modulus;

    logic [W-1:0] base_backlog[$];
    logic [W-1:0] expected_power[$];

    bit          in_fired;
    bit          out_fired;
    bit          idle_on = 1'b1;
    int unsigned tx_wait;
    int unsigned rx_wait;
    int unsigned hold_left;
    int unsigned quiet_cycles;
    int unsigned fail_count;
    int unsigned bases_taken;
    int unsigned powers_checked;
    int unsigned blocked_cycles;
    int unsigned phase_count;

    modular_exponentiation_core #(
        .OPERAND_WIDTH(W)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_base     (i_base),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_power_mod(o_power_mod)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Square-and-multiply from the low exponent bit, every product reduced
    function automatic logic [W-1:0] power_mod_of(input logic [W-1:0] b,
                                                  input logic [W-1:0] e,
                                                  input logic [W-1:0] n);
        logic [2*W-1:0] sq;
        logic [2*W-1:0] acc;
        logic [2*W-1:0] nn;
        if (n == '0) begin
            return '0;
        end
        nn = {{W{1'b0}}, n};
        sq = {{W{1'b0}}, b} % nn;
        acc = 1 % nn;
        for (int i = 0; i < W; i++) begin
            if (e[i]) begin
                acc = (acc * sq) % nn;
            end
            sq = (sq * sq) % nn;
        end
        return acc[W-1:0];
    endfunction

    // Per-transfer wait, zero for whole phases when idling is off
    function automatic int unsigned draw_gap();
        if (!idle_on || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // Track key writes, predict on each base transfer, check each result
    always @(posedge i_clk) begin
        logic [W-1:0] want;
        in_fired = i_rst_n && i_in_valid && !o_in_stall;
        out_fired = i_rst_n && o_out_valid && !i_out_stall;
        if (!i_rst_n) begin
            key_exponent = '0;
            key_modulus = 1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXPONENT: key_exponent = i_cfg_data;
                CFG_MODULUS:  key_modulus = i_cfg_data;
                default: ;
            endcase
        end
        if (in_fired) begin
            expected_power.push_back(power_mod_of(i_base, key_exponent, key_modulus));
            bases_taken++;
        end
        if (i_rst_n && i_in_valid && o_in_stall) begin
            blocked_cycles++;
        end
        if (out_fired) begin
            powers_checked++;
            if (expected_power.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected result %h with no base pending", o_power_mod);
                end
                fail_count++;
            end else begin
                want = expected_power.pop_front();
                if (o_power_mod !== want) begin
                    if (fail_count < 10) begin
                        $display("power_mod mismatch: expected %h, got %h",
                                 want, o_power_mod);
                    end
                    fail_count++;
                end
            end
        end
        // Watchdog on cycles with no transfer at all
        if (!i_rst_n || in_fired || out_fired || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Offer bases from the backlog, hold each until it transfers
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fired) begin
            if (tx_wait > 0) begin
                tx_wait--;
                i_in_valid <= 1'b0;
            end else if (base_backlog.size() != 0) begin
                i_base <= base_backlog.pop_front();
                i_in_valid <= 1'b1;
                tx_wait = draw_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Stall results at random, with two long hold-offs
    always @(negedge i_clk) begin
        if (out_fired) begin
            rx_wait = draw_gap();
            if (powers_checked == 40 || powers_checked == 180) begin
                hold_left = HOLD_CYCLES;
            end
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Block until every base has transferred and every result is back
    task automatic wait_idle();
        while (base_backlog.size() != 0 || i_in_valid || expected_power.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Load a new key once the core is idle
    task automatic load_key(input logic [W-1:0] e, input logic [W-1:0] n);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = CFG_EXPONENT;
        i_cfg_data = e;
        @(negedge i_clk);
        i_cfg_index = CFG_MODULUS;
        i_cfg_data = n;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        phase_count++;
    endtask

    function automatic logic [W-1:0] pick_base(input logic [W-1:0] n);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 1;
            2: return n - 1;
            3: return n;
            4: return '1;
            5: return (n != '0) ? ($urandom % n) : $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [W-1:0] pick_exponent();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 1;
            3: return $urandom_range(2, 300);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [W-1:0] pick_modulus();
        case ($urandom_range(0, 11))
            0: return '1;
            1: return 1;
            2: return '0;
            3: return 2;
            4: return $urandom_range(3, 5000);
            5: return 32'h8000_0000 | $urandom;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [W-1:0] n;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset key: exponent zero, modulus one
        base_backlog.push_back('0);
        base_backlog.push_back('1);

        // Exponent zero gives one, zero base included
        load_key('0, '1);
        base_backlog.push_back('0);
        base_backlog.push_back(32'd5);

        // Widest exponent and modulus; bases up to and including the modulus
        load_key('1, '1);
        base_backlog.push_back('0);
        base_backlog.push_back(32'd1);
        base_backlog.push_back('1);
        base_backlog.push_back(32'hFFFF_FFFE);
        base_backlog.push_back(32'd2);

        // Zero modulus pins the result to zero
        load_key('1, '0);
        base_backlog.push_back(32'd123);
        base_backlog.push_back('1);

        // Modulus one
        load_key(32'd65537, 32'd1);
        base_backlog.push_back(32'd7);

        // Small RSA key, base equal to and above the modulus
        load_key(32'd65537, 32'd3233);
        base_backlog.push_back(32'd65);
        base_backlog.push_back(32'd3233);
        base_backlog.push_back(32'd5000);

        // Power-of-two modulus, squaring only
        load_key(32'd2, 32'h8000_0000);
        base_backlog.push_back(32'hFFFF_FFFF);
        base_backlog.push_back(32'h7FFF_FFFF);
        base_backlog.push_back(32'hAAAA_5555);

        // Random keys and bases; every fourth phase runs without idling
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            n = pick_modulus();
            load_key(pick_exponent(), n);
            idle_on = (p % 4 != 3);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                base_backlog.push_back(pick_base(n));
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_power.size() != 0) begin
            $display("%0d results never arrived", expected_power.size());
            fail_count++;
        end

        $display("covered %0d bases under %0d key loads, %0d results checked",
                 bases_taken, phase_count, powers_checked);
        $display("input held off for %0d cycles while offered, %0d failures",
                 blocked_cycles, fail_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
